[sv/assert_macros.svh]
// Assertion helpers: clocked on clk, quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define MBPS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define MBPS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[sv/mbps_pkg.sv]
package mbps_pkg;

    localparam int PATTERN_MAX = 256;
    localparam int LEN_W       = 9;
    localparam int CMP_W       = ($clog2(PATTERN_MAX + 1) > LEN_W) ?
                                 $clog2(PATTERN_MAX + 1) : LEN_W;
    localparam int ADDR_W      = 64;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = LEN_W;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIND_ALL       = 1'd1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [7:0]        entry_index;
        logic [7:0]        byte_value;
        logic              must_compare;
        logic [ADDR_W-1:0] byte_address;
        logic              region_last;
    } in_item_t;

    typedef struct packed {
        logic              has_match;
        logic [ADDR_W-1:0] match_address;
        logic              end_of_region;
        logic              any_found;
    } out_item_t;

    typedef struct packed {
        logic load_we;
        logic step;
        logic active;
        logic clear;
    } cell_ctrl_t;

endpackage

[sv/mbps_cell.sv]
module mbps_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  mbps_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          byte_value,
    input  logic                must_compare,
    input  logic                prev,
    output logic                bit_next,
    output logic                bit_out
);

    logic [7:0] byte_reg;
    logic       mark_reg;
    logic       bit_reg;
    logic       hit;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_we)
        begin
            byte_reg <= byte_value;
            mark_reg <= must_compare;
        end
    end

    assign hit      = !mark_reg || (byte_reg == byte_value);
    assign bit_next = hit && prev && ctrl.active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            bit_reg <= bit_next && !ctrl.clear;
        end
    end

    assign bit_out = bit_reg;

endmodule

[sv/mbps_out_buf.sv]
module mbps_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mbps_pkg::out_item_t push_data,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output mbps_pkg::out_item_t out_data
);

    mbps_pkg::out_item_t main_reg;
    mbps_pkg::out_item_t skid_reg;
    logic                main_valid_reg;
    logic                skid_valid_reg;
    logic                pop;

    assign pop = main_valid_reg && !out_stall;

    // advance skid into main, or take the new beat; hold when stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

[sv/masked_byte_pattern_search.sv]
// Wildcard byte pattern search. Load beats (mode 0) write one pattern position (byte and
// compare mark); data beats (mode 1) present one memory byte with its address. One beat is
// taken per clock while in_stall is low: a row of PATTERN_MAX cells holds the pattern and the
// partial match bits, every cell compares the byte in the same cycle, and the full-match detect
// across the row settles within that cycle. A result (a match, or the end of a region) leaves
// through a two-deep output register (main and skid entries); input stalls whenever the skid
// entry is occupied.
module masked_byte_pattern_search (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  mbps_pkg::in_item_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output mbps_pkg::out_item_t                   out_data,
    input  logic                                  cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int N = mbps_pkg::PATTERN_MAX;
    localparam int W = mbps_pkg::CMP_W;

    logic [mbps_pkg::LEN_W-1:0] len_reg;
    logic                       find_all_reg;
    logic                       found_reg;
    logic                       first_done_reg;

    logic                       accept;
    logic                       load_acc;
    logic                       data_acc;
    logic [W-1:0]               len_ext;
    logic                       len_ok;
    logic [N-1:0]               bit_next;
    logic [N-1:0]               bit_cur;
    logic [N-1:0]               tail;
    logic                       match;
    logic                       report;
    logic                       found_now;
    logic                       push;
    logic                       buf_full;
    mbps_pkg::out_item_t        push_data;
    mbps_pkg::cell_ctrl_t       ctrl [N];

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;
    assign load_acc = accept && (in_data.mode == mbps_pkg::MODE_LOAD);
    assign data_acc = accept && (in_data.mode == mbps_pkg::MODE_DATA);

    assign len_ext = W'(len_reg);
    assign len_ok  = (len_ext != '0) && (len_ext <= W'(N));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            find_all_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbps_pkg::REG_PATTERN_LENGTH: len_reg      <= cfg_data;
                mbps_pkg::REG_FIND_ALL:       find_all_reg <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        assign ctrl[i].load_we = load_acc && (W'(in_data.entry_index) == W'(i));
        assign ctrl[i].step    = data_acc;
        assign ctrl[i].active  = len_ok && (len_ext > W'(i));
        assign ctrl[i].clear   = match || in_data.region_last;
        assign tail[i]         = (len_ext == W'(i + 1));

        mbps_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl[i]),
            .byte_value   (in_data.byte_value),
            .must_compare (in_data.must_compare),
            .prev         ((i == 0) ? 1'b1 : bit_cur[(i == 0) ? 0 : i - 1]),
            .bit_next     (bit_next[i]),
            .bit_out      (bit_cur[i])
        );
    end

    assign match     = |(bit_next & tail);
    assign report    = match && (find_all_reg || !first_done_reg);
    assign found_now = found_reg || report;
    assign push      = data_acc && (report || in_data.region_last);

    always_comb
    begin
        push_data.has_match     = report;
        push_data.match_address = report ?
            (in_data.byte_address - (mbps_pkg::ADDR_W'(len_reg) - 64'd1)) : '0;
        push_data.end_of_region = in_data.region_last;
        push_data.any_found     = found_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            first_done_reg <= 1'b0;
        end
        else if (data_acc)
        begin
            if (in_data.region_last)
            begin
                found_reg      <= 1'b0;
                first_done_reg <= 1'b0;
            end
            else
            begin
                found_reg      <= found_now;
                first_done_reg <= first_done_reg || (report && !find_all_reg);
            end
        end
    end

    mbps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[sv/mbps_checker.sv]
`include "assert_macros.svh"

module mbps_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  mbps_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  mbps_pkg::out_item_t out_data
);

    `MBPS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    `MBPS_ASSERT_IMP(a_beat_kind, out_valid, out_data.has_match || out_data.end_of_region)
    `MBPS_ASSERT_IMP(a_match_found, out_valid && out_data.has_match, out_data.any_found)
    `MBPS_ASSERT_IMP(a_addr_zero, out_valid && !out_data.has_match,
                     out_data.match_address == '0)
    `MBPS_ASSERT_NXT(a_load_quiet, in_valid && !in_stall && (in_data.mode == mbps_pkg::MODE_LOAD) && !out_valid,
                     !out_valid)

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
